@@ design/setp_pkg.sv @@
// Package: shared types and constants of the subtitle entry table parser.
package setp_pkg;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_SKIP,
    PH_RECORD,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_VERSION     = 3'd1,
    ST_COUNT       = 3'd2,
    ST_REC_SIZE    = 3'd3,
    ST_BELOW_TABLE = 3'd4,
    ST_OVERLAP     = 3'd5,
    ST_TRUNCATED   = 3'd6,
    ST_BACKWARD    = 3'd7
  } status_t;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_REC     = 2'd2;

  localparam logic [7:0]  RST_VERSION     = 8'd1;
  localparam logic [7:0]  RST_MAX_ENTRIES = 8'd16;
  localparam logic [15:0] RST_MIN_REC     = 16'd26;

  // header byte positions
  localparam logic [31:0] POS_VERSION = 32'd0;
  localparam logic [31:0] POS_COUNT   = 32'd1;
  localparam logic [31:0] POS_TBL_LO  = 32'd4;
  localparam logic [31:0] POS_TBL_HI  = 32'd5;
  localparam logic [15:0] HEADER_LEN  = 16'd6;

  // record field byte boundaries
  localparam logic [4:0] FB_SIZE_END = 5'd1;
  localparam logic [4:0] FB_OFF_BASE = 5'd2;
  localparam logic [4:0] FB_OFF_END  = 5'd5;
  localparam logic [4:0] FB_LEN_BASE = 5'd6;
  localparam logic [4:0] FB_KND_BASE = 5'd10;
  localparam logic [4:0] FB_TIM_BASE = 5'd14;
  localparam logic [4:0] FB_DUR_BASE = 5'd22;
  localparam logic [4:0] FB_LAST     = 5'd25;
  localparam logic [31:0] TIME_FIELD_BACK = 32'd11;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic        entry_valid;
    logic [7:0]  entry_index;
    logic [31:0] entry_kind;
    logic [63:0] entry_time;
    logic [31:0] entry_duration;
    logic [31:0] payload_offset;
    logic [31:0] payload_length;
    logic [31:0] time_field_pos;
    logic        parse_done;
    status_t     status;
    logic [7:0]  entry_total;
  } out_beat_t;

  typedef struct packed {
    logic [7:0]  expected_version;
    logic [7:0]  max_entries;
    logic [15:0] min_record_size;
  } cfg_regs_t;

endpackage

@@ design/setp_core.sv @@
// Parser state and per-byte step logic of the subtitle entry table parser.
module setp_core
  import setp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  in_beat_t  beat,
  input  cfg_regs_t cfg,
  output out_beat_t res,
  output logic      res_valid
);

  phase_t      phase, phase_next;
  logic [31:0] byte_pos, byte_pos_next;
  logic [4:0]  field_byte, field_byte_next;
  logic [7:0]  count_reg, count_reg_next;
  logic [15:0] table_offset, table_offset_next;
  logic [31:0] table_end, table_end_next;
  logic [31:0] prev_end, prev_end_next;
  logic [7:0]  index_reg, index_reg_next;
  logic [15:0] record_size_acc, record_size_acc_next;
  logic [31:0] offset_acc, offset_acc_next;
  logic [31:0] length_acc, length_acc_next;
  logic [31:0] kind_acc, kind_acc_next;
  logic [63:0] time_acc, time_acc_next;
  logic [31:0] duration_acc, duration_acc_next;
  logic        finished, finished_next;

  logic [7:0]  b;
  logic [4:0]  fb;
  logic        have_entry;
  logic        done_int;
  logic        done_now;
  status_t     status_int;
  logic [4:0]  off_lane, len_lane, knd_lane, tim_lane, dur_lane;
  logic [15:0] tbl_off_full;
  logic [23:0] tbl_span;

  assign b  = beat.in_byte;
  assign fb = field_byte;
  assign off_lane = fb - FB_OFF_BASE;
  assign len_lane = fb - FB_LEN_BASE;
  assign knd_lane = fb - FB_KND_BASE;
  assign tim_lane = fb - FB_TIM_BASE;
  assign dur_lane = fb - FB_DUR_BASE;
  assign tbl_off_full = {b, table_offset[7:0]};
  assign tbl_span = {16'd0, count_reg} * {8'd0, cfg.min_record_size};

  always_comb begin
    phase_next           = phase;
    byte_pos_next        = byte_pos + 32'd1;
    field_byte_next      = field_byte;
    count_reg_next       = count_reg;
    table_offset_next    = table_offset;
    table_end_next       = table_end;
    prev_end_next        = prev_end;
    index_reg_next       = index_reg;
    record_size_acc_next = record_size_acc;
    offset_acc_next      = offset_acc;
    length_acc_next      = length_acc;
    kind_acc_next        = kind_acc;
    time_acc_next        = time_acc;
    duration_acc_next    = duration_acc;
    finished_next        = finished;
    have_entry           = 1'b0;
    done_int             = 1'b0;
    status_int           = ST_OK;

    if (!finished) begin
      unique case (phase)
        PH_HEADER: begin
          if (byte_pos == POS_VERSION) begin
            if (b != cfg.expected_version) begin
              done_int   = 1'b1;
              status_int = ST_VERSION;
            end
          end else if (byte_pos == POS_COUNT) begin
            count_reg_next = b;
          end else if (byte_pos == POS_TBL_LO) begin
            table_offset_next = {8'd0, b};
          end else if (byte_pos == POS_TBL_HI) begin
            table_offset_next = tbl_off_full;
            if (count_reg > cfg.max_entries) begin
              done_int   = 1'b1;
              status_int = ST_COUNT;
            end else begin
              table_end_next = {16'd0, tbl_off_full} + {8'd0, tbl_span};
              priority if (count_reg == 8'd0) begin
                done_int = 1'b1;
              end else if (tbl_off_full < HEADER_LEN) begin
                done_int   = 1'b1;
                status_int = ST_BACKWARD;
              end else if (tbl_off_full == HEADER_LEN) begin
                phase_next      = PH_RECORD;
                field_byte_next = 5'd0;
              end else begin
                phase_next = PH_SKIP;
              end
            end
          end
        end
        PH_SKIP: begin
          if (byte_pos + 32'd1 == {16'd0, table_offset}) begin
            phase_next      = PH_RECORD;
            field_byte_next = 5'd0;
          end
        end
        PH_RECORD: begin
          if (fb == 5'd0) begin
            record_size_acc_next = '0;
            offset_acc_next      = '0;
            length_acc_next      = '0;
            kind_acc_next        = '0;
            time_acc_next        = '0;
            duration_acc_next    = '0;
          end
          priority if (fb < FB_OFF_BASE) begin
            record_size_acc_next[{fb[0], 3'b000} +: 8] = b;
          end else if (fb < FB_LEN_BASE) begin
            offset_acc_next[{off_lane[1:0], 3'b000} +: 8] = b;
          end else if (fb < FB_KND_BASE) begin
            length_acc_next[{len_lane[1:0], 3'b000} +: 8] = b;
          end else if (fb < FB_TIM_BASE) begin
            kind_acc_next[{knd_lane[1:0], 3'b000} +: 8] = b;
          end else if (fb < FB_DUR_BASE) begin
            time_acc_next[{tim_lane[2:0], 3'b000} +: 8] = b;
          end else begin
            duration_acc_next[{dur_lane[1:0], 3'b000} +: 8] = b;
          end

          priority if (fb == FB_SIZE_END && record_size_acc_next < cfg.min_record_size) begin
            done_int   = 1'b1;
            status_int = ST_REC_SIZE;
          end else if (fb == FB_OFF_END && offset_acc_next < table_end) begin
            done_int   = 1'b1;
            status_int = ST_BELOW_TABLE;
          end else if (fb == FB_OFF_END && offset_acc_next < prev_end) begin
            done_int   = 1'b1;
            status_int = ST_OVERLAP;
          end else if (fb == FB_LAST) begin
            have_entry      = 1'b1;
            prev_end_next   = offset_acc + length_acc;
            index_reg_next  = index_reg + 8'd1;
            field_byte_next = 5'd0;
            if (index_reg_next == count_reg) begin
              done_int = 1'b1;
            end
          end else begin
            field_byte_next = fb + 5'd1;
          end
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase
    end

    if (done_int) begin
      finished_next = 1'b1;
      phase_next    = PH_DONE;
    end
    done_now = done_int || (beat.last_byte && !finished);

    res = '0;
    if (have_entry) begin
      res.entry_valid    = 1'b1;
      res.entry_index    = index_reg;
      res.entry_kind     = kind_acc;
      res.entry_time     = time_acc;
      res.entry_duration = duration_acc_next;
      res.payload_offset = offset_acc;
      res.payload_length = length_acc;
      res.time_field_pos = byte_pos - TIME_FIELD_BACK;
    end
    if (done_now) begin
      if (!have_entry) begin
        res.entry_index = index_reg_next;
      end
      res.parse_done  = 1'b1;
      res.status      = done_int ? status_int : ST_TRUNCATED;
      res.entry_total = count_reg_next;
    end
    res_valid = have_entry || done_now;

    if (beat.last_byte) begin
      phase_next           = PH_HEADER;
      byte_pos_next        = '0;
      field_byte_next      = '0;
      count_reg_next       = '0;
      table_offset_next    = '0;
      table_end_next       = '0;
      prev_end_next        = '0;
      index_reg_next       = '0;
      record_size_acc_next = '0;
      offset_acc_next      = '0;
      length_acc_next      = '0;
      kind_acc_next        = '0;
      time_acc_next        = '0;
      duration_acc_next    = '0;
      finished_next        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      byte_pos        <= '0;
      field_byte      <= '0;
      count_reg       <= '0;
      table_offset    <= '0;
      table_end       <= '0;
      prev_end        <= '0;
      index_reg       <= '0;
      record_size_acc <= '0;
      offset_acc      <= '0;
      length_acc      <= '0;
      kind_acc        <= '0;
      time_acc        <= '0;
      duration_acc    <= '0;
      finished        <= 1'b0;
    end else if (step) begin
      phase           <= phase_next;
      byte_pos        <= byte_pos_next;
      field_byte      <= field_byte_next;
      count_reg       <= count_reg_next;
      table_offset    <= table_offset_next;
      table_end       <= table_end_next;
      prev_end        <= prev_end_next;
      index_reg       <= index_reg_next;
      record_size_acc <= record_size_acc_next;
      offset_acc      <= offset_acc_next;
      length_acc      <= length_acc_next;
      kind_acc        <= kind_acc_next;
      time_acc        <= time_acc_next;
      duration_acc    <= duration_acc_next;
      finished        <= finished_next;
    end
  end

endmodule

@@ design/subtitle_entry_table_parser.sv @@
// Top level of the subtitle entry table parser: ports, config registers, beat registers.
//
// Usage:
//   in channel  : one buffer byte per beat (in_valid / in_stall, in_data), last_byte
//                 set on the final byte of a buffer.
//   out channel : at most one result beat per input byte (out_valid / out_stall,
//                 out_data): an entry descriptor, an end-of-parse status, or both.
//   cfg channel : cfg_valid / cfg_ready, always ready; write only while idle.
// Path: an accepted byte waits in the input register; when it advances, the parse
//   logic steps and its result is captured in the out_data register.
// Throughput: one byte per cycle while out_stall is low, limited by the single input
//   register feeding the parse logic and the single result register.
// Stall: while out_stall holds a pending result, the input register fills and
//   in_stall rises in the same cycle; no beat is lost or repeated.
// Reset: rst clears both beat registers, the parser state and restores the
//   config registers (version 1, max entries 16, min record size 26).
// After a byte with last_byte set the parser is back at the header of a new
//   buffer.
module subtitle_entry_table_parser
  import setp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_beat_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_beat_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  cfg_regs_t cfg;
  in_beat_t  in_q;
  logic      in_q_valid;
  logic      advance;
  logic      in_take;
  out_beat_t core_res;
  logic      core_res_valid;

  assign cfg_ready = 1'b1;
  assign advance   = in_q_valid && (!out_valid || !out_stall);
  assign in_stall  = in_q_valid && !advance;
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_version <= RST_VERSION;
      cfg.max_entries      <= RST_MAX_ENTRIES;
      cfg.min_record_size  <= RST_MIN_REC;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_VERSION:     cfg.expected_version <= cfg_data[7:0];
        CFG_MAX_ENTRIES: cfg.max_entries      <= cfg_data[7:0];
        CFG_MIN_REC:     cfg.min_record_size  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_take) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_q <= in_data;
    end
  end

  setp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .beat      (in_q),
    .cfg       (cfg),
    .res       (core_res),
    .res_valid (core_res_valid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= core_res_valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= core_res;
    end
  end

  // a result with no descriptor must be an end-of-parse beat
  a_result_has_content: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.entry_valid) |-> out_data.parse_done)
    else $error("result beat carries neither entry nor done");

  // status codes only appear on the closing beat
  a_status_on_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.parse_done) |-> (out_data.status == ST_OK))
    else $error("nonzero status without parse_done");

  // input is held off only when a byte is already waiting
  a_stall_needs_byte: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (in_q_valid && out_valid && out_stall))
    else $error("in_stall without a pending byte and stalled result");

  // reset empties both beat registers
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_q_valid))
    else $error("beat registers not empty after reset");

endmodule
